>>> rtl/stcr_pkg.sv
// Package of the scope trace column rasterizer: display geometry, field widths,
// register indexes, controller states and the command and status structs.
// It depends on nothing else and is compiled first.
package stcr_pkg;

	// Display geometry and frame limits.
	localparam int DISPLAY_WIDTH = 128;
	localparam int MAX_SAMPLES   = 4096;
	localparam int NUM_COLS      = DISPLAY_WIDTH - 2;

	// Field widths.
	localparam int SAMPLE_W = 12;
	localparam int SCALE_W  = 12;
	localparam int COUNT_W  = 13;
	localparam int COL_W    = 7;
	localparam int ROW_W    = 6;
	localparam int MASK_W   = 64;
	localparam int IDX_W    = 13;
	localparam int PROD_W   = 20;
	localparam int NUM_W    = 18;
	localparam int DSR_W    = SCALE_W + ROW_W - 1;
	localparam int RUN_W    = 6;
	localparam int DSTEP_W  = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// Row mapping.
	localparam int ROW_TOP    = 9;
	localparam int ROW_BOT    = 54;
	localparam int ROW_SPAN   = ROW_BOT - ROW_TOP;
	localparam int MID_CODE   = 2048;
	localparam int FULL_CODE  = 4095;
	localparam int MIN_SCALE  = 256;
	localparam int MIN_COUNT  = 2;
	localparam int RESULT_CAP = 63;
	localparam int DIV_STEPS  = ROW_W;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOTTED_MODE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT    = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic div_step;
		logic emit;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic col_ok;
		logic out_free;
	} dp_status_t;

endpackage

>>> rtl/stcr_in_if.sv
// Input channel of the rasterizer: one ADC sample item with its frame mark.
// Depends on stcr_pkg.
interface stcr_in_if;
	import stcr_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_value;
	logic                start_of_frame;

	modport source (output valid, output sample_value, output start_of_frame, input ready);
	modport sink   (input valid, input sample_value, input start_of_frame, output ready);
endinterface

>>> rtl/stcr_out_if.sv
// Output channel of the rasterizer: one column item with its span and mask.
// Depends on stcr_pkg.
interface stcr_out_if;
	import stcr_pkg::*;

	logic              valid;
	logic              ready;
	logic [COL_W-1:0]  column;
	logic [ROW_W-1:0]  span_top;
	logic [ROW_W-1:0]  span_bottom;
	logic [MASK_W-1:0] column_mask;
	logic              last_of_run;

	modport source (output valid, output column, output span_top, output span_bottom,
		output column_mask, output last_of_run, input ready);
	modport sink   (input valid, input column, input span_top, input span_bottom,
		input column_mask, input last_of_run, output ready);
endinterface

>>> rtl/stcr_cfg_if.sv
// Configuration write channel of the rasterizer: register index and data.
// Depends on stcr_pkg.
interface stcr_cfg_if;
	import stcr_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/stcr_ctrl.sv
// Controller of the rasterizer: sequences accept, divide and column output.
// Depends on stcr_pkg.
module stcr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  stcr_pkg::dp_status_t  status,
	output stcr_pkg::ctl_cmd_t    cmd
);
	import stcr_pkg::*;

	ctl_state_t         state_q;
	ctl_state_t         state_d;
	logic [DSTEP_W-1:0] step_q;
	logic [DSTEP_W-1:0] step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		in_ready     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					step_d    = DSTEP_W'(DIV_STEPS - 1);
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == '0) begin
					state_d = ST_EMIT;
				end else begin
					step_d = step_q - 1'b1;
				end
			end
			ST_EMIT: begin
				// One column per cycle while the output register can take it.
				if (!status.col_ok) begin
					state_d = ST_IDLE;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// A column is only emitted while the datapath still has one to give.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit |-> status.col_ok)
		else $error("column emitted with none pending");
	// An item is only taken with the divider idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !cmd.div_step && !cmd.emit)
		else $error("item accepted while busy");
	// The divider starts on the cycle after an item is taken.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.start |=> cmd.div_step)
		else $error("divider did not start");
endmodule

>>> rtl/stcr_datapath.sv
// Datapath of the rasterizer: configuration registers, frame position, the
// shift-subtract row divider and the output register. Depends on stcr_pkg.
module stcr_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [stcr_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                  start_of_frame,
	stcr_cfg_if.sink              cfg_ch,
	stcr_out_if.source            out_ch,
	input  stcr_pkg::ctl_cmd_t    cmd,
	output stcr_pkg::dp_status_t  status
);
	import stcr_pkg::*;

	// Configuration.
	logic [SCALE_W-1:0] scale_q;
	logic               dotted_q;
	logic [COUNT_W-1:0] count_q;

	// Frame position.
	logic [COL_W-1:0]  next_col_q;
	logic [IDX_W-1:0]  idx_q;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] limit_q;
	logic [ROW_W-1:0]  prev_row_q;
	logic [RUN_W-1:0]  run_q;

	// Divider.
	logic [NUM_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [ROW_W-1:0] quo_q;

	// Output register.
	logic              out_valid_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_top_q;
	logic [ROW_W-1:0]  out_bot_q;
	logic [MASK_W-1:0] out_mask_q;
	logic              out_last_q;

	// Combinational terms.
	logic [SCALE_W-1:0]  cfg_scale;
	logic [COUNT_W-1:0]  cfg_count;
	logic [SAMPLE_W-1:0] solid_sv;
	logic [SCALE_W-2:0]  half;
	logic [SAMPLE_W-1:0] win_lo;
	logic [SAMPLE_W:0]   win_hi_wide;
	logic [SAMPLE_W-1:0] win_hi;
	logic [SAMPLE_W-1:0] dot_sv;
	logic [SAMPLE_W-1:0] num_base;
	logic [IDX_W-1:0]    idx_eff;
	logic [IDX_W:0]      idx_inc;
	logic [NUM_W:0]      rem_diff;
	logic [ROW_W-1:0]    row;
	logic [COL_W-1:0]    col;
	logic [ROW_W-1:0]    top;
	logic [ROW_W-1:0]    bot;
	logic [MASK_W-1:0]   mask;
	logic [PROD_W-1:0]   prod_next;
	logic                more_after;

	assign cfg_ch.ready = 1'b1;

	always_comb begin
		cfg_scale = cfg_ch.data[SCALE_W-1:0];
		if (cfg_scale < SCALE_W'(MIN_SCALE)) begin
			cfg_scale = SCALE_W'(MIN_SCALE);
		end
		cfg_count = cfg_ch.data[COUNT_W-1:0];
		if (cfg_count < COUNT_W'(MIN_COUNT)) begin
			cfg_count = COUNT_W'(MIN_COUNT);
		end
		if (17'(cfg_count) > 17'(MAX_SAMPLES)) begin
			cfg_count = COUNT_W'(MAX_SAMPLES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SCALE_W'(FULL_CODE);
			dotted_q <= 1'b0;
			count_q  <= COUNT_W'(128);
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				REG_AMPLITUDE_SCALE: scale_q  <= cfg_scale;
				REG_DOTTED_MODE:     dotted_q <= cfg_ch.data[0];
				REG_SAMPLE_COUNT:    count_q  <= cfg_count;
				default: begin
				end
			endcase
		end
	end

	// Numerator of the row division: the clipped sample, or its offset in
	// the window centred on mid-scale.
	always_comb begin
		solid_sv = (sample_value > scale_q) ? scale_q : sample_value;
		half        = scale_q[SCALE_W-1:1];
		win_lo      = SAMPLE_W'(MID_CODE) - SAMPLE_W'(half);
		win_hi_wide = (SAMPLE_W+1)'(MID_CODE) + (SAMPLE_W+1)'(half);
		win_hi      = (win_hi_wide > (SAMPLE_W+1)'(FULL_CODE)) ? SAMPLE_W'(FULL_CODE)
			: win_hi_wide[SAMPLE_W-1:0];
		dot_sv = sample_value;
		if (dot_sv < win_lo) begin
			dot_sv = win_lo;
		end
		if (dot_sv > win_hi) begin
			dot_sv = win_hi;
		end
		num_base = dotted_q ? (dot_sv - win_lo) : solid_sv;
		idx_eff  = start_of_frame ? '0 : idx_q;
		idx_inc  = (IDX_W+1)'(idx_eff) + 1'b1;
		rem_diff = {1'b0, rem_q} - (NUM_W+1)'(dsr_q);
	end

	// Column geometry for the column in hand.
	always_comb begin
		row = ROW_W'(ROW_BOT) - quo_q;
		col = next_col_q + 1'b1;
		top = row;
		bot = row;
		if (dotted_q) begin
			if (!col[0]) begin
				top = '0;
				bot = '0;
			end
		end else if (col != COL_W'(1) && prev_row_q >= ROW_W'(ROW_TOP)) begin
			if (prev_row_q < top) begin
				top = prev_row_q;
			end
			if (prev_row_q > bot) begin
				bot = prev_row_q;
			end
		end
		for (int i = 0; i < MASK_W; i++) begin
			mask[i] = (7'(i) >= 7'(top)) && (7'(i) <= 7'(bot));
		end
		if (dotted_q && !col[0]) begin
			mask = '0;
		end
		prod_next  = prod_q + PROD_W'(count_q);
		more_after = (next_col_q < COL_W'(NUM_COLS - 1)) && (prod_next < limit_q)
			&& (run_q < RUN_W'(RESULT_CAP - 1));
	end

	assign status.col_ok = (next_col_q < COL_W'(NUM_COLS)) && (prod_q < limit_q)
		&& (run_q < RUN_W'(RESULT_CAP));
	assign status.out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_col_q <= '0;
			idx_q      <= '0;
			prod_q     <= '0;
			limit_q    <= '0;
			prev_row_q <= '0;
			run_q      <= '0;
		end else if (cmd.start) begin
			if (start_of_frame) begin
				next_col_q <= '0;
				prod_q     <= '0;
			end
			limit_q <= PROD_W'(idx_inc) * PROD_W'(NUM_COLS);
			idx_q   <= (idx_eff == '1) ? idx_eff : idx_inc[IDX_W-1:0];
			run_q   <= '0;
		end else if (cmd.emit) begin
			next_col_q <= col;
			prod_q     <= prod_next;
			run_q      <= run_q + 1'b1;
			if (!dotted_q) begin
				prev_row_q <= row;
			end
		end
	end

	// Restoring divider: one quotient bit per step, most significant first.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= NUM_W'(num_base) * NUM_W'(ROW_SPAN);
			dsr_q <= {scale_q, {(ROW_W-1){1'b0}}};
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (!rem_diff[NUM_W]) begin
				rem_q <= rem_diff[NUM_W-1:0];
			end
			quo_q <= {quo_q[ROW_W-2:0], !rem_diff[NUM_W]};
			dsr_q <= dsr_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_col_q  <= col;
			out_top_q  <= top;
			out_bot_q  <= bot;
			out_mask_q <= mask;
			out_last_q <= !more_after;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.column      = out_col_q;
	assign out_ch.span_top    = out_top_q;
	assign out_ch.span_bottom = out_bot_q;
	assign out_ch.column_mask = out_mask_q;
	assign out_ch.last_of_run = out_last_q;

	// A column only overwrites the output register once it has been taken.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit |-> status.out_free)
		else $error("output register overwritten");
	// Each emitted column advances the frame position by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> next_col_q == $past(next_col_q) + 1'b1)
		else $error("column position did not advance");
	// A drawn span never runs outside the trace area.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_mask_q != '0 |->
		out_top_q <= out_bot_q && out_bot_q <= ROW_W'(ROW_BOT) && out_top_q >= ROW_W'(ROW_TOP))
		else $error("span outside the trace area");
endmodule

>>> rtl/scope_trace_column_rasterizer_top.sv
// Top level of the scope trace column rasterizer: joins controller and datapath.
// Depends on stcr_pkg, the three channel interfaces, stcr_ctrl and stcr_datapath.

// The rasterizer takes the 12-bit ADC samples of a frame one item at a time and
// turns them into column items for display columns 1 to 126: column c+1 is drawn
// from sample floor(c*sample_count/126), so one sample item yields zero, one or
// several column items (at most 63; any further columns follow with later samples),
// and the last column item of a sample carries last_of_run. Each column item gives
// the lit rows as a span and as a 64-bit mask with bit y for row y. In solid mode
// the sample is clipped to amplitude_scale and drawn at row 54-(v*45)/scale, each
// column after the first joining the previous row to the current one; in dotted
// mode the window is centred on code 2048 and only odd columns are lit, even
// columns still giving an item with an empty mask and a zero span. A sample item
// with start_of_frame set restarts the mapping at column 1; after reset the first
// sample counts as the start of a frame. An item is accepted, then passes the
// shift-subtract row divider, one quotient bit per step, then gives one column
// per cycle, a column waiting only while the output register has not yet been
// emptied, and ends with a closing step. The divider is the fixed cost; the
// single output register sets the column rate. Configuration writes are always
// taken and should be made only while no sample is in hand; sample_count acts
// from the next column onwards.
module scope_trace_column_rasterizer_top (
	input logic        clk,
	input logic        arst_n,
	stcr_in_if.sink    in_ch,
	stcr_out_if.source out_ch,
	stcr_cfg_if.sink   cfg_ch
);
	import stcr_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t status;
	logic       in_ready;

	// The sample item is held on the input channel only for its accept cycle;
	// the datapath captures all it needs from it then.
	assign in_ch.ready = in_ready;

	stcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	stcr_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_value   (in_ch.sample_value),
		.start_of_frame (in_ch.start_of_frame),
		.cfg_ch         (cfg_ch),
		.out_ch         (out_ch),
		.cmd            (cmd),
		.status         (status)
	);
endmodule
